// File: hw/rtl/prp_pkg.sv
package prp_pkg;

    localparam int COORD_W = 24;
    localparam int NUM_W   = 38;   // projection numerator
    localparam int DEN_W   = 25;   // depth magnitude
    localparam int Q_W     = 12;   // pixel quotient bits

    localparam logic [12:0] WIDTH_CAP = 13'd4096;

    // register indexes
    localparam logic [2:0] REG_COS    = 3'd0;
    localparam logic [2:0] REG_SIN    = 3'd1;
    localparam logic [2:0] REG_OFFSET = 3'd2;
    localparam logic [2:0] REG_FOCAL  = 3'd3;
    localparam logic [2:0] REG_WIDTH  = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [7:0]                colour;
        logic                      last;
    } side_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [Q_W-1:0]   q;
        logic             neg;
    } lane_t;

    typedef struct packed {
        side_t            side;
        logic [DEN_W-1:0] den;
        lane_t            row;
        lane_t            col;
        logic             bad;
    } div_t;

endpackage

// File: hw/rtl/point_rotate_project_unit.sv
// Rotates a Q15.8 point about z, y, then x by one shared angle and projects
// it onto a square screen. A point is taken on every cycle that start is high;
// busy stays low, so the stream can run at one beat per clock with no gaps.
// Each beat comes back marked by a one-cycle done strobe; the latency is set by
// three rotation stages, four projection stages, a twelve-stage restoring
// divider (one quotient bit per stage, two lanes for row and column) and the
// output register. The receiver cannot stall: capture results when done is
// high. Write configuration only while no beat is in flight.
module point_rotate_project_unit (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               wr_en,
    input  logic [2:0]         wr_index,
    input  logic [15:0]        wr_data,
    // command
    input  logic               start,
    output logic               busy,
    input  logic signed [23:0] point_x,
    input  logic signed [23:0] point_y,
    input  logic signed [23:0] point_z,
    input  logic [7:0]         point_colour,
    input  logic               last_point,
    // result
    output logic               done,
    output logic signed [23:0] rotated_x,
    output logic signed [23:0] rotated_y,
    output logic signed [23:0] rotated_z,
    output logic [11:0]        screen_row,
    output logic [11:0]        screen_col,
    output logic               on_screen,
    output logic [7:0]         out_colour,
    output logic               end_of_frame
);

    localparam int LATENCY = 20;

    // configuration registers
    logic signed [15:0] cos_reg, sin_reg;
    logic [14:0]        offset_reg;
    logic [11:0]        focal_reg;
    logic [12:0]        width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg    <= 16'sd16382;
            sin_reg    <= 16'sd286;
            offset_reg <= 15'd3000;
            focal_reg  <= 12'd300;
            width_reg  <= 13'd2000;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                prp_pkg::REG_COS:    cos_reg    <= wr_data;
                prp_pkg::REG_SIN:    sin_reg    <= wr_data;
                prp_pkg::REG_OFFSET: offset_reg <= wr_data[14:0];
                prp_pkg::REG_FOCAL:  focal_reg  <= wr_data[11:0];
                prp_pkg::REG_WIDTH:  width_reg  <= wr_data[12:0];
                default: ;
            endcase
        end
    end

    // effective width is capped so pixels fit 12 bits
    logic [12:0] width_eff;
    logic [11:0] half;
    assign width_eff = (width_reg > prp_pkg::WIDTH_CAP) ? prp_pkg::WIDTH_CAP : width_reg;
    assign half      = width_eff[12:1];

    assign busy = 1'b0;

    // rotation: z, then y, then x
    logic               accept;
    prp_pkg::side_t     side0, side1_in, side2_in;
    prp_pkg::side_t     sd1, sd2, sd3, rot_side;
    logic               v1, v2, v3;
    logic signed [23:0] ra1, rb1, ra2, rb2, ra3, rb3;

    assign accept = start && !busy;

    always_comb
    begin
        side0.x      = '0;
        side0.y      = '0;
        side0.z      = point_z;
        side0.colour = point_colour;
        side0.last   = last_point;

        side1_in     = sd1;
        side1_in.x   = ra1;
        side1_in.y   = rb1;

        side2_in     = sd2;
        side2_in.x   = rb2;
        side2_in.z   = ra2;

        rot_side     = sd3;
        rot_side.y   = ra3;
        rot_side.z   = rb3;
    end

    // about z: a = x, b = y
    prp_rot_stage u_rot_z (
        .clk(clk), .rst_n(rst_n), .in_valid(accept),
        .a(point_x), .b(point_y), .c(cos_reg), .s(sin_reg), .side_in(side0),
        .out_valid(v1), .a_out(ra1), .b_out(rb1), .side_out(sd1)
    );

    // about y: a = z, b = x
    prp_rot_stage u_rot_y (
        .clk(clk), .rst_n(rst_n), .in_valid(v1),
        .a(side1_in.z), .b(side1_in.x), .c(cos_reg), .s(sin_reg), .side_in(side1_in),
        .out_valid(v2), .a_out(ra2), .b_out(rb2), .side_out(sd2)
    );

    // about x: a = y, b = z
    prp_rot_stage u_rot_x (
        .clk(clk), .rst_n(rst_n), .in_valid(v2),
        .a(side2_in.y), .b(side2_in.z), .c(cos_reg), .s(sin_reg), .side_in(side2_in),
        .out_valid(v3), .a_out(ra3), .b_out(rb3), .side_out(sd3)
    );

    // projection front end
    logic          div_valid [0:prp_pkg::Q_W];
    prp_pkg::div_t div_pipe  [0:prp_pkg::Q_W];

    prp_project u_project (
        .clk(clk), .rst_n(rst_n), .in_valid(v3), .side_in(rot_side),
        .offset(offset_reg), .focal(focal_reg), .half(half),
        .out_valid(div_valid[0]), .div_out(div_pipe[0])
    );

    // divider, MSB first
    for (genvar i = 0; i < prp_pkg::Q_W; i++)
    begin : g_div
        prp_div_stage #(.BIT(prp_pkg::Q_W - 1 - i)) u_div (
            .clk(clk), .rst_n(rst_n),
            .in_valid(div_valid[i]), .div_in(div_pipe[i]),
            .out_valid(div_valid[i+1]), .div_out(div_pipe[i+1])
        );
    end

    // final check and output register
    prp_pkg::div_t fin;
    logic          row_ok, col_ok, vis_next;
    assign fin = div_pipe[prp_pkg::Q_W];

    always_comb
    begin
        // a negative quotient is off unless it truncated to zero
        row_ok   = !(fin.row.neg && (fin.row.q != '0)) && ({1'b0, fin.row.q} < width_eff);
        col_ok   = !(fin.col.neg && (fin.col.q != '0)) && ({1'b0, fin.col.q} < width_eff);
        vis_next = !fin.bad && row_ok && col_ok;
    end

    logic               done_reg, vis_reg, last_reg;
    logic signed [23:0] rx_reg, ry_reg, rz_reg;
    logic [11:0]        row_reg, col_reg;
    logic [7:0]         colour_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= div_valid[prp_pkg::Q_W];
    end

    always_ff @(posedge clk)
    begin
        rx_reg     <= fin.side.x;
        ry_reg     <= fin.side.y;
        rz_reg     <= fin.side.z;
        row_reg    <= vis_next ? fin.row.q : '0;
        col_reg    <= vis_next ? fin.col.q : '0;
        vis_reg    <= vis_next;
        colour_reg <= fin.side.colour;
        last_reg   <= fin.side.last;
    end

    assign done         = done_reg;
    assign rotated_x    = rx_reg;
    assign rotated_y    = ry_reg;
    assign rotated_z    = rz_reg;
    assign screen_row   = row_reg;
    assign screen_col   = col_reg;
    assign on_screen    = vis_reg;
    assign out_colour   = colour_reg;
    assign end_of_frame = last_reg;

    // every accepted beat returns after a fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("beat lost in pipeline");

    // no result without a beat going in
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without beat");

    // visible pixels lie inside the screen
    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (done && on_screen) |-> ({1'b0, screen_row} < width_eff
                                 && {1'b0, screen_col} < width_eff))
        else $error("pixel outside screen");

    // off-screen results carry zero pixels
    a_zero_off: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !on_screen) |-> (screen_row == '0 && screen_col == '0))
        else $error("off-screen pixel not zero");

endmodule

// File: hw/rtl/prp_rot_stage.sv
// One plane rotation: a' = a*c - b*s, b' = a*s + b*c, rounded and saturated.
module prp_rot_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic signed [23:0]    a,
    input  logic signed [23:0]    b,
    input  logic signed [15:0]    c,
    input  logic signed [15:0]    s,
    input  prp_pkg::side_t        side_in,
    output logic                  out_valid,
    output logic signed [23:0]    a_out,
    output logic signed [23:0]    b_out,
    output prp_pkg::side_t        side_out
);

    logic signed [39:0] ac, bs, as_p, bc;
    logic signed [40:0] sum_a, sum_b;
    logic signed [23:0] a_next, b_next;
    logic               valid_reg;
    logic signed [23:0] a_reg, b_reg;
    prp_pkg::side_t     side_reg;

    function automatic logic signed [23:0] rnd_sat(input logic signed [40:0] v);
        logic signed [40:0] t;
        logic signed [26:0] q;
        t = v + 41'sd8192;
        q = t[40:14];
        if (q > 27'sd8388607)
            rnd_sat = 24'sh7FFFFF;
        else if (q < -27'sd8388608)
            rnd_sat = 24'sh800000;
        else
            rnd_sat = q[23:0];
    endfunction

    always_comb
    begin
        ac     = a * c;
        bs     = b * s;
        as_p   = a * s;
        bc     = b * c;
        sum_a  = {ac[39], ac} - {bs[39], bs};
        sum_b  = {as_p[39], as_p} + {bc[39], bc};
        a_next = rnd_sat(sum_a);
        b_next = rnd_sat(sum_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        side_reg <= side_in;
    end

    assign out_valid = valid_reg;
    assign a_out     = a_reg;
    assign b_out     = b_reg;
    assign side_out  = side_reg;

endmodule

// File: hw/rtl/prp_project.sv
// Depth, numerators and magnitudes ahead of the divider: four stages.
module prp_project (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  prp_pkg::side_t side_in,
    input  logic [14:0]    offset,
    input  logic [11:0]    focal,
    input  logic [11:0]    half,
    output logic           out_valid,
    output prp_pkg::div_t  div_out
);

    logic [3:0] valid_reg;

    // stage A
    logic signed [24:0] depth_a_reg;
    logic signed [36:0] pfx_a_reg, pfy_a_reg;
    prp_pkg::side_t     side_a_reg;
    // stage B
    logic signed [24:0] depth_b_reg;
    logic signed [36:0] pfx_b_reg, pfy_b_reg;
    logic signed [37:0] hd_b_reg;
    prp_pkg::side_t     side_b_reg;
    // stage C
    logic signed [24:0] depth_c_reg;
    logic signed [37:0] nx_c_reg, ny_c_reg;
    prp_pkg::side_t     side_c_reg;
    // stage D
    prp_pkg::div_t      div_reg;

    logic signed [12:0] focal_s, half_s;
    logic [37:0]        magx, magy;
    logic [24:0]        dmag;
    logic [37:0]        dlim;
    prp_pkg::div_t      div_next;

    assign focal_s = $signed({1'b0, focal});
    assign half_s  = $signed({1'b0, half});

    always_comb
    begin
        magx = nx_c_reg[37] ? 38'(-nx_c_reg) : 38'(nx_c_reg);
        magy = ny_c_reg[37] ? 38'(-ny_c_reg) : 38'(ny_c_reg);
        dmag = depth_c_reg[24] ? 25'(-depth_c_reg) : 25'(depth_c_reg);
        dlim = {1'b0, dmag, 12'd0};
        div_next.side    = side_c_reg;
        div_next.den     = dmag;
        div_next.row.rem = magx;
        div_next.row.q   = '0;
        div_next.row.neg = nx_c_reg[37] ^ depth_c_reg[24];
        div_next.col.rem = magy;
        div_next.col.q   = '0;
        div_next.col.neg = ny_c_reg[37] ^ depth_c_reg[24];
        // zero depth lands here too: any magnitude is >= 0
        div_next.bad     = (magx >= dlim) || (magy >= dlim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        depth_a_reg <= {side_in.z[23], side_in.z} + $signed({2'b00, offset, 8'h00});
        pfx_a_reg   <= side_in.x * focal_s;
        pfy_a_reg   <= side_in.y * focal_s;
        side_a_reg  <= side_in;

        depth_b_reg <= depth_a_reg;
        pfx_b_reg   <= pfx_a_reg;
        pfy_b_reg   <= pfy_a_reg;
        hd_b_reg    <= depth_a_reg * half_s;
        side_b_reg  <= side_a_reg;

        depth_c_reg <= depth_b_reg;
        nx_c_reg    <= {pfx_b_reg[36], pfx_b_reg} + hd_b_reg;
        ny_c_reg    <= {pfy_b_reg[36], pfy_b_reg} + hd_b_reg;
        side_c_reg  <= side_b_reg;

        div_reg     <= div_next;
    end

    assign out_valid = valid_reg[3];
    assign div_out   = div_reg;

endmodule

// File: hw/rtl/prp_div_stage.sv
// One restoring step on both lanes: quotient bit BIT.
module prp_div_stage #(
    parameter int BIT = 0
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  prp_pkg::div_t div_in,
    output logic          out_valid,
    output prp_pkg::div_t div_out
);

    logic [37:0]   dsh;
    prp_pkg::div_t div_next;
    prp_pkg::div_t div_reg;
    logic          valid_reg;

    assign dsh = 38'(div_in.den) << BIT;

    always_comb
    begin
        div_next = div_in;
        if (div_in.row.rem >= dsh)
        begin
            div_next.row.rem    = div_in.row.rem - dsh;
            div_next.row.q[BIT] = 1'b1;
        end
        if (div_in.col.rem >= dsh)
        begin
            div_next.col.rem    = div_in.col.rem - dsh;
            div_next.col.q[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
    end

    assign out_valid = valid_reg;
    assign div_out   = div_reg;

endmodule
